// ===== src/tfj_pkg.sv =====
// ----------------------------------------------------------------------------
// tfj_pkg
// Shared types and constants for the text full-justify block.
// ----------------------------------------------------------------------------
package tfj_pkg;

   localparam int MaxWidth = 32;
   localparam int MaxWords = 16;
   localparam int PosW     = $clog2(MaxWidth);   // index into a line or word buffer
   localparam int WrdW     = $clog2(MaxWords);   // index into the word size table
   localparam int CntW     = PosW + 1;           // count that can reach MaxWidth
   localparam int NumW     = WrdW + 1;           // count that can reach MaxWords

   localparam logic [7:0] SpaceChar  = 8'h20;
   localparam logic [5:0] WidthReset = 6'd16;

   // one result item
   typedef struct packed {
      logic [7:0] out_char;
      logic       line_end;
      logic       error;
   } rsp_type;

   // line emit job handed from the collector to the emitter
   typedef struct packed {
      logic            justify;
      logic [NumW-1:0] words;
      logic [CntW-1:0] width;
      logic [CntW-1:0] gap_q;    // base spaces per gap
      logic [WrdW-1:0] gap_r;    // gaps below this index get one more
   } emit_job_type;

endpackage

// ===== src/tfj_divider.sv =====
// ----------------------------------------------------------------------------
// tfj_divider
// Restoring divider, one quotient bit per cycle, for the gap space split.
// ----------------------------------------------------------------------------
module tfj_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tfj_pkg::CntW-1:0]     dividend,
   input  logic [tfj_pkg::NumW-1:0]     divisor,
   output logic                         done,
   output logic [tfj_pkg::CntW-1:0]     quotient,
   output logic [tfj_pkg::NumW-1:0]     remainder
);

   logic [tfj_pkg::CntW-1:0] quo_ff, quo_in;
   logic [tfj_pkg::NumW:0]   rem_ff, rem_in;
   logic [tfj_pkg::NumW-1:0] dvs_ff, dvs_in;
   logic [tfj_pkg::PosW:0]   cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [tfj_pkg::NumW:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[tfj_pkg::NumW-1:0], quo_ff[tfj_pkg::CntW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = tfj_pkg::CntW[tfj_pkg::PosW:0];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[tfj_pkg::CntW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[tfj_pkg::CntW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[tfj_pkg::NumW-1:0];

endmodule

// ===== src/tfj_emitter.sv =====
// ----------------------------------------------------------------------------
// tfj_emitter
// Walks the line buffer and word size table and produces one line, justified
// or padded at the end, with one output register towards the result port.
// ----------------------------------------------------------------------------
module tfj_emitter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  tfj_pkg::emit_job_type        job,
   output logic                         busy,
   // line buffer read port
   output logic [tfj_pkg::PosW-1:0]     lc_raddr,
   input  logic [7:0]                   lc_rdata,
   // word size read port
   output logic [tfj_pkg::WrdW-1:0]     ws_raddr,
   input  logic [5:0]                   ws_rdata,
   // error result
   input  logic                         err_valid,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tfj_pkg::rsp_type             rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FETCH = 5'b00010,
      S_CHAR  = 5'b00100,
      S_GAP   = 5'b01000,
      S_PAD   = 5'b10000
   } emit_state_type;

   emit_state_type           state_ff, state_in;
   tfj_pkg::emit_job_type    job_ff, job_in;
   logic [tfj_pkg::NumW-1:0] widx_ff, widx_in;    // current word
   logic [5:0]               wleft_ff, wleft_in;  // chars left in current word
   logic [tfj_pkg::CntW-1:0] gleft_ff, gleft_in;  // spaces left in current gap
   logic [tfj_pkg::CntW-1:0] pos_ff, pos_in;      // read position in line buffer
   logic [tfj_pkg::CntW-1:0] done_ff, done_in;    // chars emitted so far
   logic                     ov_ff, ov_in;        // output register full
   tfj_pkg::rsp_type         ob_ff, ob_in;
   logic                     can_put;
   logic                     last_chr;
   logic [tfj_pkg::CntW-1:0] gap_len;

   assign can_put  = !ov_ff || rsp_ready;
   assign last_chr = (done_ff + 1'b1 == job_ff.width);
   // read ahead at the next position so the data lines up with pos_ff
   assign lc_raddr = pos_in[tfj_pkg::PosW-1:0];
   assign ws_raddr = widx_ff[tfj_pkg::WrdW-1:0];

   always_comb begin
      gap_len = job_ff.justify ? job_ff.gap_q : tfj_pkg::CntW'(1);
      if (job_ff.justify && (widx_ff < {1'b0, job_ff.gap_r}))
         gap_len = gap_len + 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      widx_in  = widx_ff;
      wleft_in = wleft_ff;
      gleft_in = gleft_ff;
      pos_in   = pos_ff;
      done_in  = done_ff;
      ov_in    = ov_ff && !rsp_ready;
      ob_in    = ob_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (err_valid && can_put) begin
               ov_in = 1'b1;
               ob_in = '{out_char: 8'h00, line_end: 1'b0, error: 1'b1};
            end else if (job_valid) begin
               job_in   = job;
               widx_in  = '0;
               pos_in   = '0;
               done_in  = '0;
               state_in = (job.words == 0) ? S_PAD : S_FETCH;
            end
         end
         S_FETCH: begin
            // word size read data is valid next cycle
            state_in = S_CHAR;
            wleft_in = 6'h3f;
         end
         S_CHAR: begin
            if (wleft_ff == 6'h3f) begin
               wleft_in = ws_rdata;
               if (ws_rdata == 0) state_in = S_GAP;
            end else if (done_ff == job_ff.width) begin
               state_in = S_IDLE;
            end else if (can_put) begin
               ov_in    = 1'b1;
               ob_in    = '{out_char: lc_rdata, line_end: last_chr, error: 1'b0};
               done_in  = done_ff + 1'b1;
               pos_in   = pos_ff + 1'b1;
               wleft_in = wleft_ff - 1'b1;
               if (last_chr) state_in = S_IDLE;
               else if (wleft_ff == 1) begin
                  state_in = S_GAP;
                  gleft_in = gap_len;
               end
            end
         end
         S_GAP: begin
            if (widx_ff + 1'b1 >= job_ff.words) begin
               state_in = S_PAD;
            end else if (gleft_ff == 0 || done_ff == job_ff.width) begin
               widx_in  = widx_ff + 1'b1;
               state_in = S_FETCH;
            end else if (can_put) begin
               ov_in    = 1'b1;
               ob_in    = '{out_char: tfj_pkg::SpaceChar, line_end: last_chr,
                            error: 1'b0};
               done_in  = done_ff + 1'b1;
               gleft_in = gleft_ff - 1'b1;
               if (last_chr) state_in = S_IDLE;
            end
         end
         S_PAD: begin
            if (done_ff == job_ff.width) begin
               state_in = S_IDLE;
            end else if (can_put) begin
               ov_in    = 1'b1;
               ob_in    = '{out_char: tfj_pkg::SpaceChar, line_end: last_chr,
                            error: 1'b0};
               done_in  = done_ff + 1'b1;
               if (last_chr) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      job_ff   <= job_in;
      widx_ff  <= widx_in;
      wleft_ff <= wleft_in;
      gleft_ff <= gleft_in;
      pos_ff   <= pos_in;
      done_ff  <= done_in;
      ob_ff    <= ob_in;
   end

   // busy until the last character has left the output register
   assign busy      = (state_ff != S_IDLE) || ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_data  = ob_ff;

`ifndef SYNTHESIS
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff <= job_ff.width || state_ff == S_IDLE)
      else $error("emitter ran past line width");
   a_err_flags: assert property (@(posedge clock) disable iff (reset)
      ov_ff && ob_ff.error |-> !ob_ff.line_end && ob_ff.out_char == 8'h00)
      else $error("error result carries line data");
   a_job_idle: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> state_ff == S_IDLE)
      else $error("line job issued while emitter busy");
`endif

endmodule

// ===== src/text_full_justify.sv =====
// ----------------------------------------------------------------------------
// text_full_justify
// Greedy full justification of a character stream into fixed-width lines.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/ready    ch, word_end, text_end
//   rsp      out  rsp_valid/ready    out_char, line_end, error
//   csr      in   csr_valid/ready    line_width
//
// A request that does not end a word goes into the pending word buffer. A
// word end adds a copy of the pending word into the line buffer. A line
// closed early first splits its free spaces on the bit-serial divider. A
// line goes out as line_width results, clamped to 1..MaxWidth, and requests
// stall until it has left. Reset is synchronous; the memories are not
// cleared and each entry is written before it is read.
// ----------------------------------------------------------------------------
module text_full_justify (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_word_end,
   input  logic       req_text_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_line_end,
   output logic       rsp_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [5:0] csr_line_width
);

   localparam int PosW = tfj_pkg::PosW;
   localparam int CntW = tfj_pkg::CntW;
   localparam int NumW = tfj_pkg::NumW;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_WORD  = 8'b00000010,
      S_COPY  = 8'b00000100,
      S_CFIN  = 8'b00001000,
      S_DIV   = 8'b00010000,
      S_EMIT  = 8'b00100000,
      S_WAIT  = 8'b01000000,
      S_ERR   = 8'b10000000
   } top_state_type;

   // memories
   logic [7:0] line_mem [tfj_pkg::MaxWidth];
   logic [7:0] pend_mem [tfj_pkg::MaxWidth];
   logic [5:0] size_mem [tfj_pkg::MaxWords];

   top_state_type        state_ff, state_in;
   logic [5:0]           width_ff, width_in;
   logic [NumW-1:0]      nwords_ff, nwords_in;
   logic [6:0]           fill_ff, fill_in;
   logic [CntW-1:0]      psize_ff, psize_in;
   logic                 hold_ff, hold_in;
   logic                 last_ff, last_in;       // current word ends the text
   logic                 again_ff, again_in;     // word still to be placed after emit
   logic                 just_ff, just_in;
   logic [CntW-1:0]      cidx_ff, cidx_in;       // copy index
   logic [CntW-1:0]      wsize_ff, wsize_in;     // size of word being placed
   logic [CntW-1:0]      base_ff, base_in;
   logic                 err_ff, err_in;

   logic [CntW-1:0]      weff;
   logic                 acc;
   logic [7:0]           pend_rd;
   logic [PosW-1:0]      lc_raddr;
   logic [7:0]           lc_rdata;
   logic [tfj_pkg::WrdW-1:0] ws_raddr;
   logic [5:0]           ws_rdata;
   logic                 em_busy;
   logic                 job_valid;
   tfj_pkg::emit_job_type job;
   tfj_pkg::rsp_type     rsp_data;
   logic                 div_start, div_done;
   logic [CntW-1:0]      div_q;
   logic [NumW-1:0]      div_r;
   logic [CntW-1:0]      spaces;
   logic                 pend_we;
   logic [PosW-1:0]      pend_wa;
   logic                 line_we;
   logic [PosW-1:0]      line_wa;
   logic                 size_we;
   logic [tfj_pkg::WrdW-1:0] size_wa;
   logic [6:0]           total;

   always_comb begin
      if (width_ff == 0) weff = CntW'(1);
      else if (width_ff > 6'(tfj_pkg::MaxWidth)) weff = CntW'(tfj_pkg::MaxWidth);
      else weff = width_ff[CntW-1:0];
   end

   assign total  = fill_ff - 7'(nwords_ff);
   assign spaces = (7'(weff) > total) ? CntW'(7'(weff) - total) : '0;

   assign req_ready = (state_ff == S_IDLE) && !em_busy && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE) && !em_busy;
   assign acc       = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      width_in  = width_ff;
      nwords_in = nwords_ff;
      fill_in   = fill_ff;
      psize_in  = psize_ff;
      hold_in   = hold_ff;
      last_in   = last_ff;
      again_in  = again_ff;
      just_in   = just_ff;
      cidx_in   = cidx_ff;
      wsize_in  = wsize_ff;
      base_in   = base_ff;
      err_in    = 1'b0;
      pend_we   = 1'b0;
      pend_wa   = psize_ff[PosW-1:0];
      line_we   = 1'b0;
      line_wa   = '0;
      size_we   = 1'b0;
      size_wa   = nwords_ff[tfj_pkg::WrdW-1:0];
      div_start = 1'b0;
      job_valid = 1'b0;
      job       = '{justify: just_ff, words: nwords_ff, width: weff,
                    gap_q: div_q, gap_r: div_r[tfj_pkg::WrdW-1:0]};
      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid && csr_ready) begin
               width_in  = csr_line_width;
               nwords_in = '0;
               fill_in   = '0;
               psize_in  = '0;
               hold_in   = 1'b0;
            end else if (acc) begin
               if (hold_ff) begin
                  if (req_word_end && req_text_end) hold_in = 1'b0;
               end else if (psize_ff >= weff) begin
                  err_in    = 1'b1;
                  state_in  = S_ERR;
                  nwords_in = '0;
                  fill_in   = '0;
                  psize_in  = '0;
                  hold_in   = !(req_word_end && req_text_end);
               end else begin
                  pend_we  = 1'b1;
                  psize_in = psize_ff + 1'b1;
                  if (req_word_end) begin
                     wsize_in = psize_ff + 1'b1;
                     psize_in = '0;
                     last_in  = req_text_end;
                     state_in = S_WORD;
                  end
               end
            end
         end
         S_ERR: state_in = S_IDLE;   // err_ff carries the error result to the emitter
         S_WORD: begin
            if (nwords_ff != 0 && (fill_ff + 7'(wsize_ff) > 7'(weff) ||
                nwords_ff >= NumW'(tfj_pkg::MaxWords))) begin
               // close the open line first, fully justified
               just_in  = 1'b1;
               again_in = 1'b1;
               state_in = S_DIV;
               div_start = 1'b1;
            end else begin
               base_in  = total[CntW-1:0];
               cidx_in  = '0;
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            // pend_rd holds entry cidx-1; write it at base+cidx-1
            if (cidx_ff != 0) begin
               line_we = 1'b1;
               line_wa = PosW'(base_ff + cidx_ff - 1'b1);
            end
            if (cidx_ff == wsize_ff) state_in = S_CFIN;
            else cidx_in = cidx_ff + 1'b1;
         end
         S_CFIN: begin
            size_we   = 1'b1;
            nwords_in = nwords_ff + 1'b1;
            fill_in   = fill_ff + 7'(wsize_ff) + 7'd1;
            if (fill_ff + 7'(wsize_ff) == 7'(weff) || last_ff) begin
               just_in  = 1'b0;
               again_in = 1'b0;
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            job_valid = !em_busy;
            if (!em_busy) begin
               nwords_in = '0;
               fill_in   = '0;
               state_in  = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!em_busy) begin
               if (again_ff) begin
                  again_in = 1'b0;
                  state_in = S_WORD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // a single-word line gives a zero divisor; the emitter never uses its gap split
   tfj_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (spaces),
      .divisor   (nwords_ff - 1'b1),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_ff @(posedge clock) begin
      if (pend_we) pend_mem[pend_wa] <= req_ch;
      pend_rd <= pend_mem[cidx_ff[PosW-1:0]];
      if (line_we) line_mem[line_wa] <= pend_rd;
      lc_rdata <= line_mem[lc_raddr];
      if (size_we) size_mem[size_wa] <= wsize_ff[5:0];
      ws_rdata <= size_mem[ws_raddr];
   end

   // a full-width word still lands in the buffer when line is rerun
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= tfj_pkg::WidthReset;
         nwords_ff <= '0;
         fill_ff   <= '0;
         psize_ff  <= '0;
         hold_ff   <= 1'b0;
         err_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         nwords_ff <= nwords_in;
         fill_ff   <= fill_in;
         psize_ff  <= psize_in;
         hold_ff   <= hold_in;
         err_ff    <= err_in;
      end
      last_ff  <= last_in;
      again_ff <= again_in;
      just_ff  <= just_in;
      cidx_ff  <= cidx_in;
      wsize_ff <= wsize_in;
      base_ff  <= base_in;
   end

   tfj_emitter u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .busy      (em_busy),
      .lc_raddr  (lc_raddr),
      .lc_rdata  (lc_rdata),
      .ws_raddr  (ws_raddr),
      .ws_rdata  (ws_rdata),
      .err_valid (err_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_char = rsp_data.out_char;
   assign rsp_line_end = rsp_data.line_end;
   assign rsp_error    = rsp_data.error;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 7'(weff) + 7'd1)
      else $error("open line overflows width");
   a_words_bound: assert property (@(posedge clock) disable iff (reset)
      nwords_ff <= NumW'(tfj_pkg::MaxWords))
      else $error("word count overflow");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      acc |-> !em_busy && state_ff == S_IDLE)
      else $error("request taken while line in flight");
`endif

endmodule
